[rtl/art_pkg.sv]
// ----------------------------------------------------------------------------
// art_pkg
// Types, constants and codes of the ack and retransmit tracker.
// ----------------------------------------------------------------------------
package art_pkg;

  localparam int TABLE_DEPTH  = 16;
  localparam int SLOT_W       = $clog2(TABLE_DEPTH);
  localparam int MAX_PAYLOAD  = 1392;
  localparam int HEADER_BYTES = 12;

  localparam logic [31:0] ACK_CODE         = 32'hFFFF_FFFF;
  localparam logic [15:0] AGE_MAX          = 16'hFFFF;
  localparam logic [15:0] RESET_INTERVAL   = 16'd500;
  localparam logic [31:0] RESET_UNRELIABLE = 32'hFFFF_FFFF;

  localparam logic [10:0] MAX_PAYLOAD_L = 11'(MAX_PAYLOAD);
  localparam logic [10:0] HEADER_L      = 11'(HEADER_BYTES);
  localparam logic [10:0] MAX_FRAME_L   = 11'(MAX_PAYLOAD + HEADER_BYTES);

  typedef enum logic [1:0] {
    CMD_SEND     = 2'd0,
    CMD_SEND_UNR = 2'd1,
    CMD_RECV     = 2'd2,
    CMD_TICK     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_INTERVAL   = 2'd0,
    REG_UNRELIABLE = 2'd1,
    REG_DEF_PEER   = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    ACT_TRANSMIT   = 3'd0,
    ACT_RETRANSMIT = 3'd1,
    ACT_ACK        = 3'd2,
    ACT_DELIVER    = 3'd3,
    ACT_TABLE_FULL = 3'd4,
    ACT_LEN_ERROR  = 3'd5,
    ACT_NOTHING    = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ACK_SCAN,
    S_ACK_DONE,
    S_SEND_ACK,
    S_TICK_SCAN,
    S_TICK_DONE
  } state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] seq_index;
    logic [47:0] peer;
    logic        use_default_peer;
    logic [31:0] message_code;
    logic [10:0] length;
    logic        consumer_accepts;
  } in_item_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] seq_out;
    logic [47:0] peer_out;
    logic [31:0] code_out;
    logic [10:0] length_out;
    logic [3:0]  slot;
    logic        last;
  } out_item_t;

endpackage

[rtl/art_if.sv]
// ----------------------------------------------------------------------------
// art_if
// Valid/ready channels carrying requests in and results out.
// ----------------------------------------------------------------------------
interface art_in_if import art_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface art_out_if import art_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/ack_retransmit_tracker.sv]
// ----------------------------------------------------------------------------
// ack_retransmit_tracker
// Pending-frame table with acknowledgement matching and timed resend.
// ----------------------------------------------------------------------------
// Sends and data frames need no table walk. A received ack and a millisecond
// tick walk the sixteen-entry table one slot per cycle, the tick walk pausing
// while a due slot waits on a stalled output. A retransmit is held one slot
// behind the walk so the final result of a tick can carry last. Requests are
// taken only while idle.
module ack_retransmit_tracker import art_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  art_in_if.sink      in,
  art_out_if.source   out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  logic [15:0] resend_interval_ms;
  logic [31:0] unreliable_sequence;
  logic [47:0] default_peer;

  logic [TABLE_DEPTH-1:0] slot_valid;
  logic [31:0] slot_sequence [TABLE_DEPTH];
  logic [47:0] slot_peer     [TABLE_DEPTH];
  logic [31:0] slot_code     [TABLE_DEPTH];
  logic [10:0] slot_length   [TABLE_DEPTH];
  logic [15:0] slot_age      [TABLE_DEPTH];

  state_t      state, state_next;
  in_item_t    req;
  logic [SLOT_W-1:0] idx;
  logic        out_valid;
  out_item_t   out_q;
  logic        held_v;
  out_item_t   held;

  logic        out_free;
  logic        emit;
  out_item_t   emit_item;
  logic [47:0] dst;
  logic [SLOT_W-1:0] free_slot;
  logic        have_free;
  logic [15:0] age_inc;
  logic        due;

  assign in.ready  = (state == S_IDLE);
  assign out.valid = out_valid;
  assign out.data  = out_q;
  assign out_free  = !out_valid || out.ready;
  assign dst       = req.use_default_peer ? default_peer : req.peer;
  assign age_inc   = (slot_age[idx] == AGE_MAX) ? AGE_MAX : slot_age[idx] + 16'd1;
  assign due       = slot_valid[idx] && (age_inc >= resend_interval_ms);

  always_comb begin
    free_slot = '0;
    have_free = 1'b0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_slot = SLOT_W'(i);
        have_free = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_item  = '{ACT_NOTHING, 32'd0, 48'd0, 32'd0, 11'd0, 4'd0, 1'b1};
    case (state)
      S_IDLE: begin
        if (in.valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          case (req.cmd)
            CMD_SEND, CMD_SEND_UNR: begin
              emit       = 1'b1;
              state_next = S_IDLE;
              if (req.length > MAX_PAYLOAD_L) begin
                emit_item = '{ACT_LEN_ERROR, req.seq_index, dst, req.message_code,
                              req.length, 4'd0, 1'b1};
              end else if (req.cmd == CMD_SEND_UNR) begin
                emit_item = '{ACT_TRANSMIT, unreliable_sequence, dst, req.message_code,
                              req.length + HEADER_L, 4'd0, 1'b1};
              end else if (!have_free) begin
                emit_item = '{ACT_TABLE_FULL, req.seq_index, dst, req.message_code,
                              req.length, 4'd0, 1'b1};
              end else begin
                emit_item = '{ACT_TRANSMIT, req.seq_index, dst, req.message_code,
                              req.length + HEADER_L, 4'(free_slot), 1'b1};
              end
            end
            CMD_RECV: begin
              if (req.length < HEADER_L || req.length > MAX_FRAME_L) begin
                emit       = 1'b1;
                state_next = S_IDLE;
                emit_item  = '{ACT_LEN_ERROR, req.seq_index, req.peer, req.message_code,
                               req.length, 4'd0, 1'b1};
              end else if (req.message_code == ACK_CODE) begin
                state_next = S_ACK_SCAN;
              end else begin
                emit = 1'b1;
                if (req.seq_index != unreliable_sequence && req.consumer_accepts) begin
                  state_next = S_SEND_ACK;
                  emit_item  = '{ACT_DELIVER, req.seq_index, req.peer, req.message_code,
                                 req.length - HEADER_L, 4'd0, 1'b0};
                end else begin
                  state_next = S_IDLE;
                  emit_item  = '{ACT_DELIVER, req.seq_index, req.peer, req.message_code,
                                 req.length - HEADER_L, 4'd0, 1'b1};
                end
              end
            end
            CMD_TICK: state_next = S_TICK_SCAN;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_ACK_SCAN: begin
        if (idx == SLOT_W'(TABLE_DEPTH - 1)) state_next = S_ACK_DONE;
      end
      S_ACK_DONE: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          emit_item  = '{ACT_NOTHING, req.seq_index, req.peer, req.message_code,
                         11'd0, 4'd0, 1'b1};
        end
      end
      S_SEND_ACK: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          emit_item  = '{ACT_ACK, req.seq_index, req.peer, ACK_CODE, HEADER_L,
                         4'd0, 1'b1};
        end
      end
      S_TICK_SCAN: begin
        if (!(due && held_v && !out_free)) begin
          if (due && held_v) begin
            emit      = 1'b1;
            emit_item = held;
          end
          if (idx == SLOT_W'(TABLE_DEPTH - 1)) state_next = S_TICK_DONE;
        end
      end
      S_TICK_DONE: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (held_v) begin
            emit_item      = held;
            emit_item.last = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      out_valid           <= 1'b0;
      held_v              <= 1'b0;
      idx                 <= '0;
      slot_valid          <= '0;
      resend_interval_ms  <= RESET_INTERVAL;
      unreliable_sequence <= RESET_UNRELIABLE;
      default_peer        <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_INTERVAL:   resend_interval_ms  <= cfg_data[15:0];
          REG_UNRELIABLE: unreliable_sequence <= cfg_data[31:0];
          REG_DEF_PEER:   default_peer        <= cfg_data;
          default: ;
        endcase
      end
      if (emit) out_valid <= 1'b1;
      else if (out.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          idx    <= '0;
          held_v <= 1'b0;
        end
        S_EXEC: begin
          if (out_free && req.cmd == CMD_SEND && req.length <= MAX_PAYLOAD_L && have_free)
            slot_valid[free_slot] <= 1'b1;
        end
        S_ACK_SCAN: begin
          if (slot_valid[idx] && slot_sequence[idx] == req.seq_index &&
              slot_peer[idx] == req.peer)
            slot_valid[idx] <= 1'b0;
          idx <= idx + 1'b1;
        end
        S_TICK_SCAN: begin
          if (!(due && held_v && !out_free)) begin
            if (due) held_v <= 1'b1;
            idx <= idx + 1'b1;
          end
        end
        S_TICK_DONE: begin
          if (out_free) held_v <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in.valid) req <= in.data;
    if (emit) out_q <= emit_item;
    if (state == S_EXEC && out_free && req.cmd == CMD_SEND &&
        req.length <= MAX_PAYLOAD_L && have_free) begin
      slot_sequence[free_slot] <= req.seq_index;
      slot_peer[free_slot]     <= dst;
      slot_code[free_slot]     <= req.message_code;
      slot_length[free_slot]   <= req.length;
      slot_age[free_slot]      <= 16'd0;
    end
    if (state == S_TICK_SCAN && slot_valid[idx] && !(due && held_v && !out_free)) begin
      slot_age[idx] <= due ? 16'd0 : age_inc;
      if (due) held <= '{ACT_RETRANSMIT, slot_sequence[idx], slot_peer[idx],
                         slot_code[idx], slot_length[idx] + HEADER_L, 4'(idx), 1'b0};
    end
  end

  a_held_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !held_v) else $error("held retransmit left over");

  a_one_alloc: assert property (@(posedge clk) disable iff (rst)
    $countones(slot_valid) <= $countones($past(slot_valid)) + 1)
    else $error("more than one slot taken in a cycle");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_TICK_SCAN || state == S_ACK_SCAN) |-> !in.ready)
    else $error("request taken during table walk");

endmodule
